### hdl/xsf_pkg.sv
// ============================================================================
// xsf_pkg : shared definitions for the XOR sprite frame buffer
// Sizes, codes and the control/status bundles between the top level and the
// pixel read-modify-write engine.
// ============================================================================
`default_nettype none

package xsf_pkg;

    // Frame buffer size in pixels, stored eight pixels to a memory word
    localparam int FRAME_PIXELS = 8192;
    localparam int FB_WORDS     = (FRAME_PIXELS + 7) / 8;
    localparam int FB_AW        = (FB_WORDS > 1) ? $clog2(FB_WORDS) : 1;

    // Largest address the wrap logic can form: 127 + 63 * 128
    localparam int ADDR_W = 13;

    // One lane per sprite pixel
    localparam int LANES  = 8;
    localparam int LANE_W = $clog2(LANES);

    // Display size limits and reset values
    localparam logic [7:0] WIDTH_RST  = 8'd64;
    localparam logic [6:0] HEIGHT_RST = 7'd32;
    localparam logic [7:0] WIDTH_MAX  = 8'd128;
    localparam logic [6:0] HEIGHT_MAX = 7'd64;

    // Item kinds
    localparam logic [1:0] KIND_DRAW  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

    // Commands to the pixel engine, single-cycle pulses
    typedef struct packed {
        logic draw;
        logic read;
        logic clear;
    } t_rmw_cmd;

    // Status from the pixel engine
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
        logic pixel;
    } t_rmw_stat;

endpackage

`default_nettype wire

### hdl/xsf_mod_lane.sv
// ============================================================================
// xsf_mod_lane : bit-serial remainder lane
// Restoring remainder of a 9-bit value by an 8-bit modulus, one bit a cycle while i_step is high.
// ============================================================================
`default_nettype none

module xsf_mod_lane
    import xsf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_load,
    input  wire logic       i_step,
    input  wire logic [8:0] i_num,
    input  wire logic [7:0] i_den,
    output logic      [6:0] o_rem
);

    logic [8:0] r_num;
    logic [7:0] r_den;
    logic [6:0] r_rem;
    logic [7:0] trial;
    logic [7:0] n_rem;

    // Shift in the next dividend bit, subtract the modulus when it fits
    always_comb begin
        trial = {r_rem, r_num[8]};
        if (trial >= r_den) begin
            n_rem = trial - r_den;
        end else begin
            n_rem = trial;
        end
    end

    // Load operands, then advance one bit per step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= 7'd0;
        end else if (i_step) begin
            r_num <= {r_num[7:0], 1'b0};
            r_rem <= n_rem[6:0];
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

### hdl/xsf_pixel_rmw.sv
// ============================================================================
// xsf_pixel_rmw : frame buffer memory and pixel engine
// Runs one read-modify-write per lane pixel, lane by lane, gathers the
// collision hit, serves pixel reads and sweeps the memory clear.
// ============================================================================
`default_nettype none

module xsf_pixel_rmw
    import xsf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_rmw_cmd    i_cmd,
    input  wire t_addr       i_addr [LANES],
    input  wire logic [LANES-1:0] i_bits,
    output t_rmw_stat        o_stat
);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_DRAW  = 2'd1;
    localparam logic [1:0] M_READ  = 2'd2;
    localparam logic [1:0] M_CLEAR = 2'd3;

    localparam logic [FB_AW-1:0]  CLR_LAST = FB_AW'(FB_WORDS - 1);
    localparam logic [LANE_W-1:0] IDX_LAST = LANE_W'(LANES - 1);

    logic [7:0] mem [FB_WORDS];

    logic [1:0]        r_mode;
    logic              r_wr;
    logic [LANE_W-1:0] r_idx;
    logic [FB_AW-1:0]  r_clr;
    logic              r_done;
    logic              r_hit;
    logic              r_pix;

    logic [7:0]        r_rdata;
    logic              r_cur_ok;
    logic              r_cur_bit;
    logic [2:0]        r_cur_pos;
    logic [FB_AW-1:0]  r_cur_word;

    t_addr             sel_addr;
    logic              sel_ok;
    logic [FB_AW-1:0]  sel_word;

    logic              mem_we;
    logic [FB_AW-1:0]  mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        flip;

    // Pick the pixel of the current lane
    assign sel_addr = i_addr[r_idx];
    assign sel_ok   = 32'(sel_addr) < 32'(FRAME_PIXELS);
    assign sel_word = sel_ok ? FB_AW'(sel_addr >> 3) : '0;
    assign flip     = 8'(r_cur_bit) << r_cur_pos;

    // Memory write port: clear sweep or pixel write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cur_word;
        mem_wdata = r_rdata ^ flip;
        case (r_mode)
            M_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 8'd0;
            end
            M_DRAW: begin
                mem_we = r_wr & r_cur_ok;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Frame buffer words with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[sel_word];
    end

    // Capture the pixel being read for the write-back cycle
    always_ff @(posedge i_clk) begin
        if (!r_wr) begin
            r_cur_ok   <= sel_ok;
            r_cur_bit  <= i_bits[r_idx];
            r_cur_pos  <= sel_addr[2:0];
            r_cur_word <= sel_word;
        end
    end

    // Sequence draws, reads and clear sweeps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_CLEAR;
            r_wr   <= 1'b0;
            r_idx  <= '0;
            r_clr  <= '0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
            r_pix  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_mode)
                M_IDLE: begin
                    r_wr  <= 1'b0;
                    r_idx <= '0;
                    if (i_cmd.clear) begin
                        r_mode <= M_CLEAR;
                        r_clr  <= '0;
                    end else if (i_cmd.draw) begin
                        r_mode <= M_DRAW;
                        r_hit  <= 1'b0;
                    end else if (i_cmd.read) begin
                        r_mode <= M_READ;
                    end
                end
                M_DRAW: begin
                    r_wr <= ~r_wr;
                    if (r_wr) begin
                        if (r_cur_ok && r_cur_bit && r_rdata[r_cur_pos]) begin
                            r_hit <= 1'b1;
                        end
                        if (r_idx == IDX_LAST) begin
                            r_mode <= M_IDLE;
                            r_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                M_READ: begin
                    r_wr <= ~r_wr;
                    if (r_wr) begin
                        r_pix  <= r_cur_ok & r_rdata[r_cur_pos];
                        r_mode <= M_IDLE;
                        r_done <= 1'b1;
                    end
                end
                M_CLEAR: begin
                    if (r_clr == CLR_LAST) begin
                        r_mode <= M_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                default: begin
                    r_mode <= M_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy  = (r_mode != M_IDLE);
    assign o_stat.done  = r_done;
    assign o_stat.hit   = r_hit;
    assign o_stat.pixel = r_pix;

endmodule

`default_nettype wire

### hdl/xor_sprite_framebuffer.sv
// ============================================================================
// xor_sprite_framebuffer : monochrome frame buffer with XOR sprite drawing
// Draws one sprite byte per item with wrap and collision, clears the screen
// and reads single pixels for scan-out.
// ============================================================================
//
//  channel   direction  tdata                                   tuser  tlast
//  s (in)    input      pos_x, pos_y, row_index, sprite_byte   kind   last_row
//  m (out)   output     collision, pixel_value                 -      sprite_done
//  cfg       input      write enable, index, data (width, height)
//
//  Draw runs the bit-serial wrap remainders (all lanes at once), then the row
//  multiply, then eight read-modify-writes through the frame buffer, one lane
//  after another. Read runs the same steps but ends in a single pixel read.
//  Clear sweeps all FB_WORDS (1024) memory words, one memory word a cycle.
//  After reset the same clearing pass runs before s_tready rises.
//  One item is in work at a time; a finished word waits in the output
//  register and the next item is taken while it waits.
//
`default_nettype none

module xor_sprite_framebuffer
    import xsf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [7:0] pos_x, [15:8] pos_y,
                                          // [19:16] row_index,
                                          // [27:20] sprite_byte, [31:28] zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] kind
    input  wire logic        i_s_tlast,   // last_row
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [7:0]  o_m_tdata,   // [0] collision, [1] pixel_value,
                                          // [7:2] zero
    output logic             o_m_tlast,   // sprite_done
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_RMW  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    localparam int DIV_STEPS = 9;
    localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

    logic [7:0]  r_width;
    logic [6:0]  r_height;
    logic [7:0]  w_eff;
    logic [6:0]  h_eff;

    logic [2:0]  r_state;
    logic [3:0]  r_cnt;
    logic [1:0]  r_kind;
    logic        r_last;
    logic [7:0]  r_sprite;
    logic        r_coll;
    logic        r_pix;
    t_addr       r_row_base;

    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_last;

    logic [7:0]  in_x;
    logic [7:0]  in_y;
    logic [3:0]  in_row;
    logic        s_fire;
    logic        out_free;
    logic        lane_load;
    logic        lane_step;
    logic [8:0]  y_num;
    logic [6:0]  x_rem [LANES];
    logic [6:0]  y_rem;
    logic [13:0] row_prod;
    t_addr       lane_addr [LANES];
    logic [LANES-1:0] lane_bits;

    t_rmw_cmd    cmd;
    t_rmw_stat   stat;

    assign in_x   = i_s_tdata[7:0];
    assign in_y   = i_s_tdata[15:8];
    assign in_row = i_s_tdata[19:16];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIDTH:  r_width  <= i_cfg_wdata;
                REG_HEIGHT: r_height <= i_cfg_wdata[6:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    // Clamp display size into its usable range
    always_comb begin
        if (r_width == 8'd0) begin
            w_eff = 8'd1;
        end else if (r_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_width;
        end
        if (r_height == 7'd0) begin
            h_eff = 7'd1;
        end else if (r_height > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = r_height;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid & o_s_tready;
    assign out_free   = ~r_out_valid | i_m_tready;
    assign lane_load  = s_fire;
    assign lane_step  = (r_state == S_DIV);
    assign y_num      = {1'b0, in_y} + ((i_s_tuser == KIND_DRAW) ? {5'd0, in_row} : 9'd0);

    // Column wrap lanes, one per sprite pixel, MSB in lane zero
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        xsf_mod_lane u_xlane (
            .i_clk  (i_clk),
            .i_load (lane_load),
            .i_step (lane_step),
            .i_num  ({1'b0, in_x} + 9'(g)),
            .i_den  (w_eff),
            .o_rem  (x_rem[g])
        );
        assign lane_addr[g] = ADDR_W'(x_rem[g]) + r_row_base;
        assign lane_bits[g] = r_sprite[LANES-1-g];
    end

    // Row wrap lane
    xsf_mod_lane u_ylane (
        .i_clk  (i_clk),
        .i_load (lane_load),
        .i_step (lane_step),
        .i_num  (y_num),
        .i_den  ({1'b0, h_eff}),
        .o_rem  (y_rem)
    );

    assign row_prod = {7'd0, y_rem} * {6'd0, w_eff};

    // Engine commands
    assign cmd.draw  = (r_state == S_MUL) && (r_kind == KIND_DRAW);
    assign cmd.read  = (r_state == S_MUL) && (r_kind == KIND_READ);
    assign cmd.clear = s_fire && (i_s_tuser == KIND_CLEAR);

    xsf_pixel_rmw u_rmw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_addr  (lane_addr),
        .i_bits  (lane_bits),
        .o_stat  (stat)
    );

    // Item sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= 4'd0;
            r_coll  <= 1'b0;
        end else begin
            case (r_state)
                S_INIT: begin
                    if (!stat.busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        r_cnt <= 4'd0;
                        case (i_s_tuser)
                            KIND_DRAW: begin
                                if (in_row == 4'd0) begin
                                    r_coll <= 1'b0;
                                end
                                r_state <= S_DIV;
                            end
                            KIND_READ:  r_state <= S_DIV;
                            KIND_CLEAR: r_state <= S_CLR;
                            default:    r_state <= S_RES;
                        endcase
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_RMW;
                end
                S_RMW: begin
                    if (stat.done) begin
                        if (r_kind == KIND_DRAW) begin
                            r_coll <= r_coll | stat.hit;
                        end
                        r_state <= S_RES;
                    end
                end
                S_CLR: begin
                    if (stat.done) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload, row base and pixel read result
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_kind   <= i_s_tuser;
            r_last   <= i_s_tlast;
            r_sprite <= i_s_tdata[27:20];
        end
        if (r_state == S_MUL) begin
            r_row_base <= row_prod[ADDR_W-1:0];
        end
        if ((r_state == S_RMW) && stat.done) begin
            r_pix <= stat.pixel;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RES) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RES) && out_free) begin
            r_out_data <= {6'd0,
                           (r_kind == KIND_READ) & r_pix,
                           (r_kind == KIND_DRAW) & r_coll};
            r_out_last <= (r_kind == KIND_DRAW) & r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

### hdl/xsf_checker.sv
// ============================================================================
// xsf_checker : port-level checks for the XOR sprite frame buffer
// Watches the stream ports over time; bound to the top level.
// ============================================================================
`default_nettype none

module xsf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [31:0] i_s_tdata,
    input wire logic [1:0]  i_s_tuser,
    input wire logic        i_s_tlast,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic        o_m_tlast,
    input wire logic        i_cfg_we,
    input wire logic        i_cfg_addr,
    input wire logic [7:0]  i_cfg_wdata
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // Drop ready after taking a word: one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // A sprite end never carries a pixel read
    a_done_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tdata[1])
        else $error("sprite_done together with pixel_value");

    // Collision and pixel value come from different kinds
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("collision and pixel_value both set");

    // Reset empties the output and blocks input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("output or ready active after reset");

endmodule

bind xor_sprite_framebuffer xsf_checker u_checker (.*);

`default_nettype wire
